// ===== rtl/rem_pkg.sv =====
// Shared types and constants for the rotary encoder settings menu.
`default_nettype none
package rem_pkg;

   localparam int unsigned LAST_SCROLL_PAGE = 6;
   localparam int unsigned FIFO_DEPTH       = 4;
   localparam int unsigned FIFO_AW          = $clog2(FIFO_DEPTH);

   localparam logic signed [7:0]  UTC_LOW    = -8'sd48;
   localparam logic signed [7:0]  UTC_HIGH   = 8'sd56;
   localparam logic [40:0]        SECS_DAY   = 41'd86400;
   localparam logic [40:0]        SECS_MONTH = 41'd2629743;
   localparam logic [40:0]        SECS_YEAR  = 41'd31556926;
   localparam logic [39:0]        W40_MAX    = 40'h7F_FFFF_FFFF;
   localparam logic [39:0]        W40_MIN    = 40'h80_0000_0000;

   localparam logic [1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [1:0] CSR_UTC      = 2'd1;
   localparam logic [1:0] CSR_BIRTH    = 2'd2;
   localparam logic [1:0] CSR_DEATH    = 2'd3;

   localparam logic [1:0] FIELD_YEAR  = 2'd0;
   localparam logic [1:0] FIELD_MONTH = 2'd1;
   localparam logic [1:0] FIELD_DAY   = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_NEXT  = 2'd1,
      OP_PREV  = 2'd2,
      OP_PRESS = 2'd3
   } rem_op_type;

   typedef enum logic [3:0] {
      PAGE_TIME       = 4'd0,
      PAGE_YEAR       = 4'd1,
      PAGE_LIFE       = 4'd2,
      PAGE_SHOW_UTC   = 4'd3,
      PAGE_SHOW_BIRTH = 4'd4,
      PAGE_SHOW_DEATH = 4'd5,
      PAGE_NTP        = 4'd6,
      PAGE_SET_UTC    = 4'd7,
      PAGE_SET_BIRTH  = 4'd8,
      PAGE_SET_DEATH  = 4'd9
   } rem_page_type;

   typedef struct packed {
      logic       we;
      logic [1:0] index;
      logic [39:0] wdata;
   } rem_csr_type;

endpackage
`default_nettype wire

// ===== rtl/rem_front.sv =====
// Front end: accepts requests, detects encoder edges and debounces presses.
`default_nettype none
module rem_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rem_pkg::rem_csr_type csr,
   input  wire logic               in_valid,
   input  wire logic               in_action,
   input  wire logic               in_clk_level,
   input  wire logic               in_dt_level,
   input  wire logic [31:0]        in_now_ms,
   input  wire logic               push_ready,
   output rem_pkg::rem_op_type     push_op,
   output logic                    push_valid
);

   logic        last_clk_ff, last_clk_in;
   logic [31:0] last_press_ff, last_press_in;
   logic [15:0] debounce_ff, debounce_in;
   logic [31:0] elapsed;
   logic        accept;

   assign accept     = in_valid && push_ready;
   assign push_valid = in_valid;
   assign elapsed    = in_now_ms - last_press_ff;

   always_comb begin
      last_clk_in   = last_clk_ff;
      last_press_in = last_press_ff;
      debounce_in   = debounce_ff;
      push_op       = rem_pkg::OP_NONE;
      if (in_action) begin
         if (elapsed >= {16'd0, debounce_ff}) begin
            push_op = rem_pkg::OP_PRESS;
         end
      end else if (in_clk_level && !last_clk_ff) begin
         push_op = in_dt_level ? rem_pkg::OP_NEXT : rem_pkg::OP_PREV;
      end
      if (accept) begin
         if (in_action) begin
            last_press_in = in_now_ms;
         end else begin
            last_clk_in = in_clk_level;
         end
      end
      if (csr.we && csr.index == rem_pkg::CSR_DEBOUNCE) begin
         debounce_in = csr.wdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_clk_ff   <= 1'b1;
         last_press_ff <= '0;
         debounce_ff   <= 16'd50;
      end else begin
         last_clk_ff   <= last_clk_in;
         last_press_ff <= last_press_in;
         debounce_ff   <= debounce_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rem_fifo.sv =====
// Short queue of classified operations between the front and back ends.
`default_nettype none
module rem_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire rem_pkg::rem_op_type push_op,
   output logic                     push_ready,
   output logic                     pop_valid,
   output rem_pkg::rem_op_type      pop_op,
   input  wire logic                pop_ready
);

   rem_pkg::rem_op_type slot_ff [rem_pkg::FIFO_DEPTH];
   logic [rem_pkg::FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rem_pkg::FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rem_pkg::FIFO_AW:0]   count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != rem_pkg::FIFO_DEPTH[rem_pkg::FIFO_AW:0]);
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rem_back.sv =====
// Back end: applies operations to the menu state and holds the result register.
`default_nettype none
module rem_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rem_pkg::rem_csr_type csr,
   input  wire logic                op_valid,
   input  wire rem_pkg::rem_op_type op,
   output logic                     op_ready,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [95:0]              out_data
);

   rem_pkg::rem_page_type page_ff, page_in;
   logic [1:0]            field_ff, field_in;
   logic signed [6:0]     utc_ff, utc_in;
   logic [39:0]           birth_ff, birth_in;
   logic [39:0]           death_ff, death_in;
   logic                  valid_ff, valid_in;
   logic [95:0]           data_ff, data_in;

   logic        save, resync, dir_up, date_ok;
   logic [40:0] step, date_sum;
   logic [39:0] date_sel, date_new;
   logic signed [7:0] utc_sum, utc_cfg, utc_new;

   assign op_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign dir_up    = (op == rem_pkg::OP_NEXT);

   always_comb begin
      date_ok = 1'b1;
      case (field_ff)
         rem_pkg::FIELD_YEAR:  step = rem_pkg::SECS_YEAR;
         rem_pkg::FIELD_MONTH: step = rem_pkg::SECS_MONTH;
         rem_pkg::FIELD_DAY:   step = rem_pkg::SECS_DAY;
         default: begin
            step    = '0;
            date_ok = 1'b0;
         end
      endcase
      date_sel = (page_ff == rem_pkg::PAGE_SET_BIRTH) ? birth_ff : death_ff;
      date_sum = {date_sel[39], date_sel} + (dir_up ? step : (~step + 41'd1));
      if (date_sum[40] != date_sum[39]) begin
         date_new = date_sum[40] ? rem_pkg::W40_MIN : rem_pkg::W40_MAX;
      end else begin
         date_new = date_sum[39:0];
      end
      if (!date_ok) begin
         date_new = date_sel;
      end

      utc_sum = {utc_ff[6], utc_ff} + (dir_up ? 8'sd1 : -8'sd1);
      if (utc_sum < rem_pkg::UTC_LOW) begin
         utc_new = rem_pkg::UTC_LOW;
      end else if (utc_sum > rem_pkg::UTC_HIGH) begin
         utc_new = rem_pkg::UTC_HIGH;
      end else begin
         utc_new = utc_sum;
      end

      utc_cfg = {csr.wdata[6], csr.wdata[6:0]};
      if (utc_cfg < rem_pkg::UTC_LOW) begin
         utc_cfg = rem_pkg::UTC_LOW;
      end else if (utc_cfg > rem_pkg::UTC_HIGH) begin
         utc_cfg = rem_pkg::UTC_HIGH;
      end
   end

   always_comb begin
      page_in  = page_ff;
      field_in = field_ff;
      utc_in   = utc_ff;
      birth_in = birth_ff;
      death_in = death_ff;
      save     = 1'b0;
      resync   = 1'b0;
      valid_in = valid_ff && !out_ready;
      data_in  = data_ff;

      if (op_valid && op_ready) begin
         if (op == rem_pkg::OP_NEXT || op == rem_pkg::OP_PREV) begin
            case (page_ff)
               rem_pkg::PAGE_SET_UTC:   utc_in = utc_new[6:0];
               rem_pkg::PAGE_SET_BIRTH: birth_in = date_new;
               rem_pkg::PAGE_SET_DEATH: death_in = date_new;
               default: begin
                  if (dir_up) begin
                     page_in = (page_ff >= 4'(rem_pkg::LAST_SCROLL_PAGE)) ?
                        rem_pkg::PAGE_TIME : rem_pkg::rem_page_type'(page_ff + 4'd1);
                  end else begin
                     page_in = (page_ff == rem_pkg::PAGE_TIME) ?
                        rem_pkg::rem_page_type'(4'(rem_pkg::LAST_SCROLL_PAGE)) :
                        rem_pkg::rem_page_type'(page_ff - 4'd1);
                  end
               end
            endcase
         end else if (op == rem_pkg::OP_PRESS) begin
            case (page_ff)
               rem_pkg::PAGE_SHOW_UTC:   page_in = rem_pkg::PAGE_SET_UTC;
               rem_pkg::PAGE_SHOW_BIRTH: page_in = rem_pkg::PAGE_SET_BIRTH;
               rem_pkg::PAGE_SHOW_DEATH: page_in = rem_pkg::PAGE_SET_DEATH;
               rem_pkg::PAGE_NTP: begin
                  resync  = 1'b1;
                  page_in = rem_pkg::PAGE_TIME;
               end
               rem_pkg::PAGE_SET_UTC: begin
                  page_in = rem_pkg::PAGE_SHOW_UTC;
                  save    = 1'b1;
                  resync  = 1'b1;
               end
               rem_pkg::PAGE_SET_BIRTH, rem_pkg::PAGE_SET_DEATH: begin
                  field_in = field_ff + 2'd1;
                  if (field_ff >= rem_pkg::FIELD_DAY) begin
                     page_in  = (page_ff == rem_pkg::PAGE_SET_BIRTH) ?
                        rem_pkg::PAGE_SHOW_BIRTH : rem_pkg::PAGE_SHOW_DEATH;
                     save     = 1'b1;
                     field_in = rem_pkg::FIELD_YEAR;
                  end
               end
               default: ;
            endcase
         end
         valid_in = 1'b1;
         data_in  = {1'b0, resync, save, death_in, birth_in, utc_in, field_in,
                     4'(page_in)};
      end

      if (csr.we) begin
         case (csr.index)
            rem_pkg::CSR_UTC:   utc_in = utc_cfg[6:0];
            rem_pkg::CSR_BIRTH: birth_in = csr.wdata;
            rem_pkg::CSR_DEATH: death_in = csr.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff  <= rem_pkg::PAGE_TIME;
         field_ff <= rem_pkg::FIELD_YEAR;
         utc_ff   <= '0;
         birth_ff <= '0;
         death_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         page_ff  <= page_in;
         field_ff <= field_in;
         utc_ff   <= utc_in;
         birth_ff <= birth_in;
         death_ff <= death_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

// ===== rtl/rotary_encoder_settings_menu_top.sv =====
// Top level of the rotary encoder settings menu.
// Throughput: one request per cycle while the queue is not full; a four-entry queue
// decouples intake from the state update, and the back end registers each response.
// The state update (one 41-bit add with saturation) sets the per-cycle work of the back end.
// Synchronous active-high reset restores the register defaults and empties the queue.
`default_nettype none
module rotary_encoder_settings_menu_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [39:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // clk_level, dt_level, now_ms[31:0], zero pad
   input  wire logic        req_tuser,  // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata   // page, date_field, utc_quarters, birth_seconds,
                                        // death_seconds, save_request, resync_request, pad
);

   rem_pkg::rem_csr_type csr;
   rem_pkg::rem_op_type  push_op, pop_op;
   logic push_valid, push_ready, pop_valid, pop_ready;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;
   assign req_tready = push_ready;

   rem_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr),
      .in_valid     (req_tvalid),
      .in_action    (req_tuser),
      .in_clk_level (req_tdata[0]),
      .in_dt_level  (req_tdata[1]),
      .in_now_ms    (req_tdata[33:2]),
      .push_ready   (push_ready),
      .push_op      (push_op),
      .push_valid   (push_valid)
   );

   rem_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_op     (pop_op),
      .pop_ready  (pop_ready)
   );

   rem_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .op_valid  (pop_valid),
      .op        (pop_op),
      .op_ready  (pop_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== rtl/rem_checker.sv =====
// Port-level checks for the rotary encoder settings menu, bound to the top level.
`default_nettype none
module rem_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [95:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_page_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:0] <= rem_pkg::PAGE_SET_DEATH &&
         rsp_tdata[5:4] <= rem_pkg::FIELD_DAY)
      else $error("page or date field out of range");

   a_utc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[12:6]) >= -7'sd48 && $signed(rsp_tdata[12:6]) <= 7'sd56)
      else $error("utc offset out of range");

   a_save_page: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[93] |->
         rsp_tdata[3:0] == rem_pkg::PAGE_SHOW_UTC ||
         rsp_tdata[3:0] == rem_pkg::PAGE_SHOW_BIRTH ||
         rsp_tdata[3:0] == rem_pkg::PAGE_SHOW_DEATH)
      else $error("save request off a show page");

endmodule

bind rotary_encoder_settings_menu_top rem_checker u_rem_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
